// ===== src/assert_macros.svh =====
// ============================================================================
// Assertion macros
// Concurrent assertion wrappers shared by the RTL; empty in synthesis.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication: when ante holds, cons holds on the same edge.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication: when ante holds, cons holds on the following edge.
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== src/tstl_pkg.sv =====
// ============================================================================
// tstl_pkg
// Types, codes and helpers of the text symbol table lookup.
// ============================================================================
package tstl_pkg;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_ADDR = 3'd1,
        PH_SIZE = 3'd2,
        PH_COPY = 3'd3,
        PH_SKIP = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        KIND_NAME      = 2'd0,
        KIND_FOUND     = 2'd1,
        KIND_NOT_FOUND = 2'd2
    } t_kind;

    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

    // Result queue geometry.
    localparam int OUT_DEPTH = 4;
    localparam int PTR_W     = 2;
    localparam int CNT_W     = 3;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  name_byte;
        logic [31:0] base_address;
        logic        last_result;
    } t_out_item;

    // Up to two results per table byte, pushed in order.
    typedef struct packed {
        logic [1:0] cnt;
        t_out_item  item0;
        t_out_item  item1;
    } t_push;

    // Hex digit value; any other byte counts as zero.
    function automatic logic [3:0] digit_value(input logic [7:0] c);
        logic [7:0] d;
        begin
            d = 8'd0;
            if (c >= 8'h30 && c <= 8'h39) begin
                d = c - 8'h30;
            end else if (c >= 8'h41 && c <= 8'h46) begin
                d = c - 8'h37;
            end else if (c >= 8'h61 && c <= 8'h66) begin
                d = c - 8'h57;
            end
            return d[3:0];
        end
    endfunction

endpackage

// ===== src/tstl_if.sv =====
// ============================================================================
// tstl_in_if / tstl_out_if
// Valid/ready channels of the text symbol table lookup.
// ============================================================================
interface tstl_in_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [31:0] query_address;
    logic [8:0]  name_limit;
    logic [7:0]  table_byte;
    logic        last_byte;

    modport source (output valid, cmd, query_address, name_limit, table_byte, last_byte,
                    input ready);
    modport sink   (input valid, cmd, query_address, name_limit, table_byte, last_byte,
                    output ready);
endinterface

interface tstl_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  name_byte;
    logic [31:0] base_address;
    logic        last_result;

    modport source (output valid, kind, name_byte, base_address, last_result,
                    input ready);
    modport sink   (input valid, kind, name_byte, base_address, last_result,
                    output ready);
endinterface

// ===== src/tstl_out_fifo.sv =====
// ============================================================================
// tstl_out_fifo
// Four-entry result queue: up to two pushes and one pop per cycle.
// ============================================================================
`include "assert_macros.svh"

module tstl_out_fifo (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tstl_pkg::t_push               i_push,
    output logic [tstl_pkg::CNT_W-1:0]    o_count,
    tstl_out_if.source                    o_out
);
    import tstl_pkg::*;

    t_out_item        mem [OUT_DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_count, n_count;
    logic             pop;

    assign pop = o_out.valid && o_out.ready;

    always_comb begin
        n_wr    = r_wr + PTR_W'(i_push.cnt);
        n_rd    = r_rd + PTR_W'(pop);
        n_count = r_count + CNT_W'(i_push.cnt) - CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            mem[r_wr] <= i_push.item0;
        end
        if (i_push.cnt == 2'd2) begin
            mem[r_wr + PTR_W'(1)] <= i_push.item1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    assign o_count            = r_count;
    assign o_out.valid        = (r_count != '0);
    assign o_out.kind         = mem[r_rd].kind;
    assign o_out.name_byte    = mem[r_rd].name_byte;
    assign o_out.base_address = mem[r_rd].base_address;
    assign o_out.last_result  = mem[r_rd].last_result;

    `ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(OUT_DEPTH))
    `ASSERT_IMP(a_push_fits, i_clk, i_rst_n, 1'b1, (r_count + CNT_W'(i_push.cnt)) <= CNT_W'(OUT_DEPTH))
    `ASSERT_IMP(a_ptr_gap, i_clk, i_rst_n, r_count != CNT_W'(OUT_DEPTH), PTR_W'(r_wr - r_rd) == r_count[PTR_W-1:0])

endmodule

// ===== src/text_symbol_table_lookup.sv =====
// ============================================================================
// text_symbol_table_lookup
// Looks up an address in a text symbol table streamed one byte per transfer.
// ============================================================================
//
//  channel  direction  payload                                          role
//  i_in     sink       cmd, query_address, name_limit, table_byte,      start / table byte
//                      last_byte
//  o_out    source     kind, name_byte, base_address, last_result       name byte / verdict
//
//  One input transfer per cycle while the queue has room: a transfer lands in the
//  input register and is then evaluated by a single shift-add or add-compare step.
//  Results (zero, one or two per transfer) go into a four-entry queue; the held
//  transfer is evaluated only while the queue holds two entries or fewer.
//  Reset is synchronous, active low; the block comes out idle with no query.
//  A stalled output drops i_in.ready, while a transfer is held, once the queue holds three results or more.
//
`include "assert_macros.svh"

module text_symbol_table_lookup #(
    parameter int MAX_NAME_BYTES = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tstl_in_if.sink    i_in,
    tstl_out_if.source o_out
);
    import tstl_pkg::*;

    // Copied-byte counter and limit-minus-one share this width.
    localparam int CW = $clog2(MAX_NAME_BYTES);

    // Input register.
    logic        r_in_valid;
    logic        r_cmd;
    logic [31:0] r_query_in;
    logic [8:0]  r_limit_in;
    logic [7:0]  r_byte;
    logic        r_last;

    // Scan state.
    t_phase      r_phase, n_phase;
    logic [31:0] r_addr, n_addr;
    logic [31:0] r_size, n_size;
    logic [31:0] r_query, n_query;
    logic [CW-1:0] r_lim_m1, n_lim_m1;
    logic [CW-1:0] r_copied, n_copied;

    logic                process;
    logic [CNT_W-1:0]    q_count;
    t_push               push;
    logic                verdict_push;

    logic        is_space;
    logic        is_newline;
    logic [3:0]  digit;
    logic [31:0] span_end;
    logic        hit;
    logic        copy_done;
    logic [31:0] lim_m1_full;
    t_out_item   found_item;
    t_out_item   miss_item;
    t_out_item   name_item;

    // Evaluate the held transfer only when the queue can take two results.
    assign process    = r_in_valid && (q_count <= CNT_W'(OUT_DEPTH - 2));
    assign i_in.ready = !r_in_valid || process;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_cmd      <= i_in.cmd;
            r_query_in <= i_in.query_address;
            r_limit_in <= i_in.name_limit;
            r_byte     <= i_in.table_byte;
            r_last     <= i_in.last_byte;
        end
    end

    // Shared decode of the held byte.
    assign is_space   = (r_byte == CHAR_SPACE);
    assign is_newline = (r_byte == CHAR_NEWLINE);
    assign digit      = digit_value(r_byte);
    assign span_end   = r_addr + r_size;
    assign hit        = (r_query >= r_addr) && (r_query < span_end);
    assign copy_done  = ({1'b0, r_copied} + (CW + 1)'(1)) >= {1'b0, r_lim_m1};

    // Clamp the name limit to 1..MAX_NAME_BYTES, stored as limit minus one.
    always_comb begin
        lim_m1_full = (r_limit_in == 9'd0) ? 32'd0 : ({23'd0, r_limit_in} - 32'd1);
        if (lim_m1_full > 32'(MAX_NAME_BYTES - 1)) begin
            lim_m1_full = 32'(MAX_NAME_BYTES - 1);
        end
    end

    // Next state.
    always_comb begin
        n_phase  = r_phase;
        n_addr   = r_addr;
        n_size   = r_size;
        n_query  = r_query;
        n_lim_m1 = r_lim_m1;
        n_copied = r_copied;
        if (!r_cmd) begin
            n_query  = r_query_in;
            n_lim_m1 = lim_m1_full[CW-1:0];
            n_addr   = '0;
            n_size   = '0;
            n_copied = '0;
            n_phase  = PH_ADDR;
        end else if (r_phase != PH_IDLE) begin
            unique case (r_phase)
                PH_ADDR: begin
                    if (is_space) begin
                        n_size  = '0;
                        n_phase = PH_SIZE;
                    end else begin
                        // Low nibble is zero after the shift, so OR adds the digit.
                        n_addr = {r_addr[27:0], digit};
                    end
                end
                PH_SIZE: begin
                    if (is_space) begin
                        if (hit) begin
                            n_copied = '0;
                            n_phase  = (r_lim_m1 == '0) ? PH_IDLE : PH_COPY;
                        end else begin
                            n_phase = PH_SKIP;
                        end
                    end else begin
                        n_size = {r_size[28:0], 3'b000} + {r_size[30:0], 1'b0}
                                 + {28'd0, digit};
                    end
                end
                PH_SKIP: begin
                    if (is_newline) begin
                        n_addr  = '0;
                        n_size  = '0;
                        n_phase = PH_ADDR;
                    end
                end
                PH_COPY: begin
                    if (is_newline) begin
                        n_phase = PH_IDLE;
                    end else begin
                        n_copied = r_copied + CW'(1);
                        if (copy_done) begin
                            n_phase = PH_IDLE;
                        end
                    end
                end
                default: n_phase = PH_IDLE;
            endcase
            // End of table closes any query still open.
            if (r_last) begin
                n_phase = PH_IDLE;
            end
        end
    end

    // Result items.
    assign found_item = '{kind: KIND_FOUND, name_byte: 8'd0, base_address: r_addr,
                          last_result: 1'b1};
    assign miss_item  = '{kind: KIND_NOT_FOUND, name_byte: 8'd0, base_address: 32'd0,
                          last_result: 1'b1};
    assign name_item  = '{kind: KIND_NAME, name_byte: r_byte, base_address: 32'd0,
                          last_result: 1'b0};

    always_comb begin
        push.cnt   = 2'd0;
        push.item0 = found_item;
        push.item1 = found_item;
        if (process && r_cmd && r_phase != PH_IDLE) begin
            unique case (r_phase)
                PH_ADDR, PH_SKIP: begin
                    if (r_last) begin
                        push.cnt   = 2'd1;
                        push.item0 = miss_item;
                    end
                end
                PH_SIZE: begin
                    if (is_space && hit) begin
                        // A limit of one reports at once; otherwise a closing table
                        // still reports found since copying had begun.
                        if (r_lim_m1 == '0 || r_last) begin
                            push.cnt = 2'd1;
                        end
                    end else if (r_last) begin
                        push.cnt   = 2'd1;
                        push.item0 = miss_item;
                    end
                end
                PH_COPY: begin
                    if (is_newline) begin
                        push.cnt = 2'd1;
                    end else begin
                        push.item0 = name_item;
                        push.cnt   = (copy_done || r_last) ? 2'd2 : 2'd1;
                    end
                end
                default: push.cnt = 2'd0;
            endcase
        end
    end

    // A closing verdict sits in the last slot that this cycle pushes.
    assign verdict_push = (push.cnt == 2'd1 && push.item0.last_result)
                          || (push.cnt == 2'd2 && push.item1.last_result);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_addr   <= '0;
            r_size   <= '0;
            r_query  <= '0;
            r_lim_m1 <= '0;
            r_copied <= '0;
        end else if (process) begin
            r_phase  <= n_phase;
            r_addr   <= n_addr;
            r_size   <= n_size;
            r_query  <= n_query;
            r_lim_m1 <= n_lim_m1;
            r_copied <= n_copied;
        end
    end

    tstl_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_count (q_count),
        .o_out   (o_out)
    );

    // Copying always stops before the counter reaches the limit.
    `ASSERT_IMP(a_copy_bound, i_clk, i_rst_n, r_phase == PH_COPY, r_copied < r_lim_m1)
    // A closing verdict leaves the scan idle.
    `ASSERT_NXT(a_verdict_idle, i_clk, i_rst_n, verdict_push, r_phase == PH_IDLE)
    // Results come only from byte transfers of a running query.
    `ASSERT_IMP(a_push_source, i_clk, i_rst_n, push.cnt != 2'd0, process && r_cmd && r_phase != PH_IDLE)

endmodule
